// File: rtl/core/csw_pkg.sv
// Package of shared widths, constants and helpers for the cube surface wave pixel block.
package csw_pkg;

  localparam int DEF_GRID_WIDTH  = 8;
  localparam int DEF_GRID_HEIGHT = 8;

  // Signed width of a distance component, enough for the whole grid range.
  localparam int DIST_W = 9;
  // Width of the squared distance sum.
  localparam int SUM_W = 16;
  // Width of the Q.8 root and of the phase.
  localparam int ROOT_W  = 16;
  localparam int PHASE_W = 16;
  localparam int CFG_W   = 16;
  // Two root iterations per pipeline stage.
  localparam int ROOT_STAGES = 8;
  localparam int ROOT_WORK_W = 33;

  localparam int WAVE_STEP_RESET    = 512;
  localparam int SPATIAL_RATE_RESET = 4096;

  // Polynomial sine coefficients.
  localparam int SIN_C3 = 4639;
  localparam int SIN_C2 = 42047;
  localparam int SIN_C1 = 102944;

  typedef enum logic [0:0] {
    REG_WAVE_STEP    = 1'b0,
    REG_SPATIAL_RATE = 1'b1
  } reg_index_t;

  // Width of a stored origin coordinate: the field width, or more if the
  // reset value (half the grid) needs it.
  function automatic int org_w(input int n);
    int w;
    w = $clog2(n / 2 + 1);
    return (w > 3) ? w : 3;
  endfunction

endpackage

// File: rtl/core/csw_dist.sv
// Distance stages: surface offsets from the origin and their sum of squares.
module csw_dist #(
  parameter int GRID_WIDTH  = csw_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = csw_pkg::DEF_GRID_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [2:0]                   face,
  input  logic [2:0]                   col,
  input  logic [2:0]                   row,
  input  logic [2:0]                   oface,
  input  logic [csw_pkg::org_w(GRID_WIDTH)-1:0]  ocol,
  input  logic [csw_pkg::org_w(GRID_HEIGHT)-1:0] orow,
  input  logic [csw_pkg::PHASE_W-1:0]  phase,
  output logic                         out_v,
  output logic [csw_pkg::SUM_W-1:0]    sum,
  output logic [csw_pkg::PHASE_W-1:0]  phase_o
);

  localparam int DW   = csw_pkg::DIST_W;
  localparam int HALF = GRID_WIDTH / 2;

  logic signed [DW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [DW-1:0] col_d, row_d;
  logic signed [2*DW-1:0] sqx, sqy;
  logic [csw_pkg::PHASE_W-1:0] ph1_r, ph2_r;
  logic [csw_pkg::SUM_W-1:0] sum_r;
  logic v1_r, v2_r;

  always_comb begin
    col_d = DW'(col) - DW'(ocol);
    row_d = DW'(row) - DW'(orow);
    if (face == oface) begin
      dx_nxt = col_d;
      dy_nxt = row_d;
    end else if (face <= 3'd3) begin
      dx_nxt = DW'(HALF + GRID_WIDTH);
      dy_nxt = row_d;
    end else if (face == 3'd4) begin
      dx_nxt = col_d;
      dy_nxt = DW'(HALF - GRID_HEIGHT);
    end else begin
      dx_nxt = col_d;
      dy_nxt = DW'(HALF + GRID_HEIGHT);
    end
  end

  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      ph1_r <= phase;
      sum_r <= csw_pkg::SUM_W'(sqx) + csw_pkg::SUM_W'(sqy);
      ph2_r <= ph1_r;
    end
  end

  assign out_v   = v2_r;
  assign sum     = sum_r;
  assign phase_o = ph2_r;

endmodule

// File: rtl/core/csw_root.sv
// Pipelined bit-serial square root, two iterations per stage, result in Q.8.
module csw_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [csw_pkg::SUM_W-1:0]   sum,
  input  logic [csw_pkg::PHASE_W-1:0] phase,
  output logic                        out_v,
  output logic [csw_pkg::ROOT_W-1:0]  dist_q8,
  output logic [csw_pkg::PHASE_W-1:0] phase_o
);

  localparam int N  = csw_pkg::ROOT_STAGES;
  localparam int WW = csw_pkg::ROOT_WORK_W;

  logic [WW-1:0] rem_r [1:N];
  logic [WW-1:0] res_r [1:N];
  logic [csw_pkg::PHASE_W-1:0] ph_r [1:N];
  logic [N:1] v_r;

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [WW-1:0] rem_in, res_in, rem_nxt, res_nxt;
    logic [csw_pkg::PHASE_W-1:0] ph_in;
    logic v_in;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, sum, 16'b0};
      assign res_in = '0;
      assign ph_in  = phase;
      assign v_in   = in_v;
    end else begin : g_next
      assign rem_in = rem_r[j];
      assign res_in = res_r[j];
      assign ph_in  = ph_r[j];
      assign v_in   = v_r[j];
    end

    always_comb begin : p_step
      logic [WW-1:0] rm, rs, b;
      rm = rem_in;
      rs = res_in;
      for (int k = 0; k < 2; k++) begin
        b = WW'(1) << (30 - 2 * (2 * j + k));
        if (rm >= rs + b) begin
          rm = rm - (rs + b);
          rs = (rs >> 1) + b;
        end else begin
          rs = rs >> 1;
        end
      end
      rem_nxt = rm;
      res_nxt = rs;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= rem_nxt;
        res_r[j+1] <= res_nxt;
        ph_r[j+1]  <= ph_in;
      end
    end
  end

  assign out_v   = v_r[N];
  assign dist_q8 = res_r[N][csw_pkg::ROOT_W-1:0];
  assign phase_o = ph_r[N];

endmodule

// File: rtl/core/csw_wave.sv
// Wave stages: angle from distance and phase, polynomial sine, colour scaling.
module csw_wave (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [csw_pkg::ROOT_W-1:0]  dist_q8,
  input  logic [csw_pkg::PHASE_W-1:0] phase,
  input  logic [csw_pkg::CFG_W-1:0]   spatial_rate,
  output logic                        out_v,
  output logic [6:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue
);

  logic [6:0] v_r;
  logic [31:0] prod_r;
  logic [15:0] ph_m_r, angle_r;
  logic [14:0] t_m;
  logic [16:0] big_c;
  logic [33:0] tt_c;
  logic [16:0] big1_r, t2_1_r, big2_r, t2_2_r, big3_r, mid_r, wave_r;
  logic [1:0] q1_r, q2_r, q3_r;
  logic [29:0] p2_c;
  logic [15:0] inner_r;
  logic [32:0] p3_c;
  logic [33:0] p4_c;
  logic [17:0] s_c;
  logic [16:0] s_cl;
  logic [23:0] pr_c, pg_c, pb_c;
  logic [6:0] red_r;
  logic [7:0] green_r, blue_r;

  always_comb begin
    t_m = angle_r[14] ? (15'd16384 - {1'b0, angle_r[13:0]}) : {1'b0, angle_r[13:0]};
    big_c = {t_m, 2'b00};
    tt_c  = 34'(big_c) * 34'(big_c);
    p2_c  = 30'(csw_pkg::SIN_C3) * 30'(t2_1_r);
    p3_c  = 33'(t2_2_r) * 33'(inner_r);
    p4_c  = 34'(big3_r) * 34'(mid_r);
    s_c   = p4_c[33:16];
    s_cl  = (s_c > 18'd65536) ? 17'd65536 : s_c[16:0];
    pr_c  = 24'(wave_r) * 24'd100;
    pg_c  = 24'(wave_r) * 24'd150;
    pb_c  = 24'(wave_r) * 24'd255;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 32'(dist_q8) * 32'(spatial_rate);
      ph_m_r  <= phase;
      angle_r <= prod_r[23:8] - ph_m_r;
      big1_r  <= big_c;
      t2_1_r  <= tt_c[32:16];
      q1_r    <= angle_r[15:14];
      big2_r  <= big1_r;
      t2_2_r  <= t2_1_r;
      q2_r    <= q1_r;
      inner_r <= 16'(csw_pkg::SIN_C2) - 16'(p2_c[29:16]);
      big3_r  <= big2_r;
      q3_r    <= q2_r;
      mid_r   <= 17'(csw_pkg::SIN_C1) - p3_c[32:16];
      wave_r  <= q3_r[1] ? (17'd32768 - (s_cl >> 1)) : (17'd32768 + (s_cl >> 1));
      red_r   <= pr_c[22:16];
      green_r <= pg_c[23:16] + 8'd50;
      blue_r  <= pb_c[23:16];
    end
  end

  assign out_v = v_r[6];
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// File: rtl/core/cube_surface_wave_pixel.sv
// Top level of the cube surface wave pixel block: state, pipeline and output buffering.
//
// Input transactions carry a command in in_tuser: a frame transaction (0) advances
// the wave phase by wave_step and, with load_origin set, loads face, col and row as
// the new ripple origin; it yields no result. A pixel transaction (1) yields exactly
// one colour transaction on the out_ channel, in the order the pixels arrived.
// Frame transactions take effect at once, so every pixel sees the phase and origin
// left by the transactions before it.
// The pixel path is an 18-stage pipeline: two distance stages, eight square root
// stages of two iterations each, seven angle, sine and colour stages, and the output
// register. One transaction is accepted in every cycle while in_tready is high; the
// rate is set by the single pipeline. When the receiver stalls, the output register
// holds its colour and a one-entry skid buffer catches the next one; only once the
// skid buffer is full is in_tready dropped and the whole pipeline frozen, so nothing
// is lost or repeated. Registers are written through cfg_wr_en, cfg_index and
// cfg_wdata; the user must do so only while idle, which the block does not enforce.
// Synchronous reset clears the phase, sets the origin to face 0 at the grid centre,
// restores the register defaults and empties the pipeline.
module cube_surface_wave_pixel #(
  parameter int GRID_WIDTH  = csw_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = csw_pkg::DEF_GRID_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // face [2:0], col [5:3], row [8:6], load_origin [9]
  input  logic        in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red [6:0], green [14:7], blue [22:15]
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int OCW = csw_pkg::org_w(GRID_WIDTH);
  localparam int ORW = csw_pkg::org_w(GRID_HEIGHT);

  // Configuration and block state.
  logic [15:0] wave_step_r, spatial_rate_r, phase_r;
  logic [2:0] origin_face_r;
  logic [OCW-1:0] origin_col_r;
  logic [ORW-1:0] origin_row_r;

  logic en, accept, pixel;
  logic d_v, r_v, w_v;
  logic [csw_pkg::SUM_W-1:0] d_sum;
  logic [15:0] d_ph, r_ph;
  logic [csw_pkg::ROOT_W-1:0] r_dist;
  logic [6:0] w_red;
  logic [7:0] w_green, w_blue;

  logic out_v_r, skid_v_r;
  logic [22:0] out_d_r, skid_d_r;

  // The pipeline moves whenever the skid buffer is empty.
  assign en        = !skid_v_r;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign pixel     = accept && in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_step_r    <= 16'(csw_pkg::WAVE_STEP_RESET);
      spatial_rate_r <= 16'(csw_pkg::SPATIAL_RATE_RESET);
      phase_r        <= '0;
      origin_face_r  <= '0;
      origin_col_r   <= OCW'(GRID_WIDTH / 2);
      origin_row_r   <= ORW'(GRID_HEIGHT / 2);
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          csw_pkg::REG_WAVE_STEP:    wave_step_r    <= cfg_wdata;
          csw_pkg::REG_SPATIAL_RATE: spatial_rate_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && !in_tuser) begin
        phase_r <= phase_r + wave_step_r;
        if (in_tdata[9]) begin
          origin_face_r <= in_tdata[2:0];
          origin_col_r  <= OCW'(in_tdata[5:3]);
          origin_row_r  <= ORW'(in_tdata[8:6]);
        end
      end
    end
  end

  csw_dist #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (pixel),
    .face   (in_tdata[2:0]),
    .col    (in_tdata[5:3]),
    .row    (in_tdata[8:6]),
    .oface  (origin_face_r),
    .ocol   (origin_col_r),
    .orow   (origin_row_r),
    .phase  (phase_r),
    .out_v  (d_v),
    .sum    (d_sum),
    .phase_o(d_ph)
  );

  csw_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (d_v),
    .sum    (d_sum),
    .phase  (d_ph),
    .out_v  (r_v),
    .dist_q8(r_dist),
    .phase_o(r_ph)
  );

  csw_wave u_wave (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (r_v),
    .dist_q8     (r_dist),
    .phase       (r_ph),
    .spatial_rate(spatial_rate_r),
    .out_v       (w_v),
    .red         (w_red),
    .green       (w_green),
    .blue        (w_blue)
  );

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (w_v) begin
      if (!out_v_r || out_tready) begin
        out_d_r <= {w_blue, w_green, w_red};
        out_v_r <= 1'b1;
      end else begin
        skid_d_r <= {w_blue, w_green, w_red};
        skid_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_d_r};

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid buffer holds a colour while the output register is empty");

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tuser) |=> (phase_r == $past(16'(phase_r + wave_step_r))))
    else $error("frame transaction did not advance the phase by wave_step");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && !skid_v_r && w_v) |=> skid_v_r)
    else $error("stalled colour was not caught by the skid buffer");
`endif

endmodule

// File: tb/sv/cube_surface_wave_pixel_test.sv
// Self-checking testbench for the cube surface wave pixel block.
module cube_surface_wave_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = 8;
  localparam int GH = 8;
  localparam int PIPE_LATENCY = 18;
  localparam longint CYCLE_LIMIT = 400000;
  localparam bit CMD_FRAME = 1'b0;
  localparam bit CMD_PIXEL = 1'b1;

  // Laid out as on out_tdata: red in the lowest bits, blue in the highest.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [6:0] red;
  } colour_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  cube_surface_wave_pixel #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // The predictor's own copy of the block's state and registers.
  logic [15:0] wave_step_q;
  logic [15:0] spatial_rate_q;
  logic [15:0] phase_q;
  logic [2:0]  org_face_q;
  int          org_col_q;
  int          org_row_q;

  colour_t     colour_queue[$];
  int          error_count;
  longint      cycle_count;
  bit          sender_idle_on;
  bit          receiver_idle_on;
  bit          hold_receiver;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run-away guard: the slowest correct run stays far below this limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cube_surface_wave_pixel_test: done, errors");
      $finish;
    end
  end

  // Sixteen-step bit-serial square root, giving the distance in Q.8.
  function automatic logic [15:0] root_of_sum(input logic [31:0] sum);
    logic [63:0] v, res, bitv;
    v = {32'd0, sum} << 16;
    res = 0;
    bitv = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[15:0];
  endfunction

  // Polynomial sine mapped onto 0 .. 65536.
  function automatic logic [16:0] wave_at(input logic [15:0] angle);
    logic [1:0]  quad;
    logic [63:0] t, big, t2, inner, mid, s;
    quad = angle[15:14];
    t = angle[13:0];
    if (quad[0]) t = 64'h4000 - t;
    big = t << 2;
    t2 = (big * big) >> 16;
    inner = csw_pkg::SIN_C2 - ((csw_pkg::SIN_C3 * t2) >> 16);
    mid = csw_pkg::SIN_C1 - ((t2 * inner) >> 16);
    s = (big * mid) >> 16;
    if (s > 65536) s = 65536;
    if (quad < 2) return 17'(32768 + (s >> 1));
    return 17'(32768 - (s >> 1));
  endfunction

  // Colour of one pixel from the current phase, origin and spatial rate.
  function automatic colour_t pixel_colour(input logic [2:0] face, input int col,
                                           input int row);
    int          dx, dy;
    logic [31:0] sum;
    logic [63:0] scaled;
    logic [15:0] angle;
    logic [63:0] w;
    colour_t     c;
    if (face == org_face_q) begin
      dx = col - org_col_q;
      dy = row - org_row_q;
    end else if (face <= 3) begin
      dx = GW / 2 + GW;
      dy = row - org_row_q;
    end else begin
      dx = col - org_col_q;
      dy = GW / 2 + ((face == 4) ? -GH : GH);
    end
    sum = 32'(dx * dx) + 32'(dy * dy);
    scaled = (64'(root_of_sum(sum)) * spatial_rate_q) >> 8;
    angle = scaled[15:0] - phase_q;
    w = wave_at(angle);
    c.red = 7'((w * 100) >> 16);
    c.green = 8'(((w * 150) >> 16) + 50);
    c.blue = 8'((w * 255) >> 16);
    return c;
  endfunction

  // Offers one item, waits for its acceptance and updates the prediction.
  task automatic send_item(input bit cmd, input logic [2:0] face, input logic [2:0] col,
                           input logic [2:0] row, input bit load);
    int gap;
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, load, row, col, face};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_FRAME) begin
      phase_q = phase_q + wave_step_q;
      if (load) begin
        org_face_q = face;
        org_col_q = col;
        org_row_q = row;
      end
    end else begin
      colour_queue.push_back(pixel_colour(face, col, row));
    end
  endtask

  task automatic send_random_item(input int pixel_weight);
    bit cmd;
    cmd = ($urandom_range(0, 99) < pixel_weight) ? CMD_PIXEL : CMD_FRAME;
    send_item(cmd, 3'($urandom), 3'($urandom), 3'($urandom), 1'($urandom));
  endtask

  // Drops valid, waits until every colour has arrived and the pipeline has drained.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // One write, then cfg_wr_en is dropped so that back-to-back writes stay apart.
  task automatic write_register(input csw_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == csw_pkg::REG_WAVE_STEP) wave_step_q = value;
    else spatial_rate_q = value;
  endtask

  // Result checker: compares each accepted colour with the oldest prediction.
  always @(posedge clk) begin
    colour_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[22:0];
      if (colour_queue.size() == 0) begin
        $error("unexpected colour transaction %h", out_tdata);
        error_count++;
      end else begin
        want = colour_queue.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          error_count++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          error_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_receiver = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Extremes of every field, both commands, face codes six and seven, and
  // an origin stored with an out-of-range face.
  task automatic test_directed();
    send_item(CMD_PIXEL, 3'd0, 3'd4, 3'd4, 1'b0);
    send_item(CMD_PIXEL, 3'd0, 3'd0, 3'd0, 1'b1);
    send_item(CMD_PIXEL, 3'd0, 3'd7, 3'd7, 1'b0);
    for (int f = 1; f < 8; f++) send_item(CMD_PIXEL, 3'(f), 3'd7, 3'd0, 1'b0);
    send_item(CMD_FRAME, 3'd5, 3'd7, 3'd7, 1'b0);
    send_item(CMD_PIXEL, 3'd0, 3'd4, 3'd4, 1'b0);
    send_item(CMD_FRAME, 3'd3, 3'd0, 3'd7, 1'b1);
    send_item(CMD_PIXEL, 3'd3, 3'd0, 3'd7, 1'b0);
    send_item(CMD_PIXEL, 3'd4, 3'd7, 3'd0, 1'b0);
    send_item(CMD_FRAME, 3'd7, 3'd7, 3'd7, 1'b1);
    send_item(CMD_PIXEL, 3'd7, 3'd0, 3'd0, 1'b0);
    send_item(CMD_PIXEL, 3'd6, 3'd0, 3'd0, 1'b1);
    send_item(CMD_FRAME, 3'd6, 3'd2, 3'd5, 1'b1);
    send_item(CMD_PIXEL, 3'd6, 3'd5, 3'd2, 1'b0);
    send_item(CMD_PIXEL, 3'd7, 3'd5, 3'd2, 1'b0);
    wait_idle();
  endtask

  // Register extremes, including a wave step that wraps the phase quickly.
  task automatic test_register_settings();
    logic [15:0] steps[4] = '{16'hFFFF, 16'd0, 16'd1, 16'h8000};
    logic [15:0] rates[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd777};
    for (int k = 0; k < 4; k++) begin
      write_register(csw_pkg::REG_WAVE_STEP, steps[k]);
      write_register(csw_pkg::REG_SPATIAL_RATE, rates[k]);
      repeat (60) send_random_item(60);
      wait_idle();
    end
  endtask

  // Receiver holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    repeat (80) send_random_item(100);
    wait_idle();
  endtask

  // Random mix with random register values, then a final stretch with no idling.
  task automatic test_random_stream();
    for (int phase_n = 0; phase_n < 4; phase_n++) begin
      write_register(csw_pkg::REG_WAVE_STEP, 16'($urandom));
      write_register(csw_pkg::REG_SPATIAL_RATE, 16'($urandom));
      repeat (150) send_random_item(75);
      wait_idle();
    end
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    repeat (200) send_random_item(75);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = csw_pkg::REG_WAVE_STEP;
    cfg_wdata = '0;
    cycle_count = 0;
    error_count = 0;
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    hold_receiver = 1'b0;
    wave_step_q = 16'(csw_pkg::WAVE_STEP_RESET);
    spatial_rate_q = 16'(csw_pkg::SPATIAL_RATE_RESET);
    phase_q = 0;
    org_face_q = 0;
    org_col_q = GW / 2;
    org_row_q = GH / 2;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_settings();
    test_backpressure();
    test_random_stream();
    wait_idle();

    if (error_count == 0) begin
      $display("cube_surface_wave_pixel_test: done, clean");
    end else begin
      $display("cube_surface_wave_pixel_test: done, errors");
    end
    $finish;
  end

endmodule
